// File: rtl/assert_macros.svh
// Assertion macros shared by the controller RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising edge of clk outside reset.
`define PPSY_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PPSY_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ppsy_pkg.sv
// Shared types and constants for the pure pursuit speed and yaw controller.
`default_nettype none
package ppsy_pkg;

  // CORDIC internals, Q30 with two guard bits
  localparam int CORDIC_STEPS = 30;
  localparam int XW           = 34;
  localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [XW-1:0] PI_Q30          = 34'sd3373259426;
  localparam logic signed [XW-1:0] HALF_PI_Q30     = 34'sd1686629713;

  // restoring divider: one overflow bit plus 17 quotient bits
  localparam int DQW = 18;
  // product register width (31 x 11 bit for the yaw numerator)
  localparam int PAW = 42;
  localparam logic [10:0] YAW_GAIN = 11'd2000;

  // register map indexes
  localparam logic [2:0] REG_SPEED_MAX    = 3'd0;
  localparam logic [2:0] REG_SPEED_MIN    = 3'd1;
  localparam logic [2:0] REG_CURV_GAIN    = 3'd2;
  localparam logic [2:0] REG_YAW_MAX      = 3'd3;
  localparam logic [2:0] REG_LOOK_MIN     = 3'd4;
  localparam logic [2:0] REG_TIMEOUT      = 3'd5;

  // register reset values
  localparam logic [14:0] RST_SPEED_MAX = 15'd2048;
  localparam logic [14:0] RST_SPEED_MIN = 15'd410;
  localparam logic [15:0] RST_CURV_GAIN = 16'd500;
  localparam logic [14:0] RST_YAW_MAX   = 15'd8192;
  localparam logic [15:0] RST_LOOK_MIN  = 16'd50;
  localparam logic [7:0]  RST_TIMEOUT   = 8'd5;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_SAMPLE,
    OP_CORDIC,
    OP_COSFIN,
    OP_SMUL,
    OP_SDIV_LOAD,
    OP_DIV_STEP,
    OP_SFIN,
    OP_YMUL1,
    OP_YMUL2,
    OP_YDIV_LOAD,
    OP_YFIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic div_last;
    logic stale_hit;
  } dp_stat_t;

  // arctangent table, Q30
  function automatic logic signed [XW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [XW-1:0] v;
    unique case (idx)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048576;
      5'd11:   v = 34'sd524288;
      5'd12:   v = 34'sd262144;
      5'd13:   v = 34'sd131072;
      5'd14:   v = 34'sd65536;
      5'd15:   v = 34'sd32768;
      5'd16:   v = 34'sd16384;
      5'd17:   v = 34'sd8192;
      5'd18:   v = 34'sd4096;
      5'd19:   v = 34'sd2048;
      5'd20:   v = 34'sd1024;
      5'd21:   v = 34'sd512;
      5'd22:   v = 34'sd256;
      5'd23:   v = 34'sd128;
      5'd24:   v = 34'sd64;
      5'd25:   v = 34'sd32;
      5'd26:   v = 34'sd16;
      5'd27:   v = 34'sd8;
      5'd28:   v = 34'sd4;
      5'd29:   v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ppsy_in_if.sv
// Input channel: error samples and watchdog ticks.
`default_nettype none
interface ppsy_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] lateral_error_mm;
  logic        [15:0] lookahead_mm;
  logic signed [14:0] heading_error;
  logic signed [15:0] curvature;

  modport source (output valid, kind, lateral_error_mm, lookahead_mm, heading_error,
                  curvature, input ready);
  modport sink   (input valid, kind, lateral_error_mm, lookahead_mm, heading_error,
                  curvature, output ready);
endinterface
`default_nettype wire

// File: rtl/ppsy_out_if.sv
// Result channel: drive commands.
`default_nettype none
interface ppsy_out_if;
  logic               valid;
  logic               ready;
  logic        [14:0] speed;
  logic signed [15:0] yaw_rate;
  logic               stale;

  modport source (output valid, speed, yaw_rate, stale, input ready);
  modport sink   (input valid, speed, yaw_rate, stale, output ready);
endinterface
`default_nettype wire

// File: rtl/pure_pursuit_speed_yaw_controller_core.sv
// Pure pursuit speed and yaw controller: top level with register file.
//
// Each error sample yields one drive command: 30 CORDIC iterations for the
// cosine, two 18-step restoring divisions (speed quotient and yaw quotient)
// on one shared divider, and the multiply, load and finish steps between
// them. The next item is taken in the cycle after the command is loaded. A
// watchdog tick is handled in S_IDLE alone, or passes through S_DONE as well
// when it emits a stale command. Items are handled one
// at a time; a finished word waits in the output register while the next item
// is worked on, and the block stalls if that word is still not taken when the
// next one is done. Registers are written through the APB port at byte address
// 4*index and read back the same way.
`default_nettype none
module pure_pursuit_speed_yaw_controller_core #(
  parameter int COS_FRACTION_BITS = 12,
  parameter int AGE_BITS          = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ppsy_in_if.sink     in_ch,
  ppsy_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [14:0] speed_max_r, speed_max_nxt;
  logic [14:0] speed_min_r, speed_min_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic [14:0] yaw_max_r, yaw_max_nxt;
  logic [15:0] look_min_r, look_min_nxt;
  logic [7:0]  timeout_r, timeout_nxt;
  logic        wr_en;
  logic [2:0]  reg_idx;

  ppsy_pkg::dp_cmd_t  cmd;
  ppsy_pkg::dp_stat_t stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // register writes
  always_comb begin
    speed_max_nxt = speed_max_r;
    speed_min_nxt = speed_min_r;
    gain_nxt      = gain_r;
    yaw_max_nxt   = yaw_max_r;
    look_min_nxt  = look_min_r;
    timeout_nxt   = timeout_r;
    if (wr_en) begin
      unique case (reg_idx)
        ppsy_pkg::REG_SPEED_MAX: speed_max_nxt = pwdata[14:0];
        ppsy_pkg::REG_SPEED_MIN: speed_min_nxt = pwdata[14:0];
        ppsy_pkg::REG_CURV_GAIN: gain_nxt      = pwdata[15:0];
        ppsy_pkg::REG_YAW_MAX:   yaw_max_nxt   = pwdata[14:0];
        ppsy_pkg::REG_LOOK_MIN:  look_min_nxt  = pwdata[15:0];
        ppsy_pkg::REG_TIMEOUT:   timeout_nxt   = pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      ppsy_pkg::REG_SPEED_MAX: prdata = 32'(speed_max_r);
      ppsy_pkg::REG_SPEED_MIN: prdata = 32'(speed_min_r);
      ppsy_pkg::REG_CURV_GAIN: prdata = 32'(gain_r);
      ppsy_pkg::REG_YAW_MAX:   prdata = 32'(yaw_max_r);
      ppsy_pkg::REG_LOOK_MIN:  prdata = 32'(look_min_r);
      ppsy_pkg::REG_TIMEOUT:   prdata = 32'(timeout_r);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_max_r <= ppsy_pkg::RST_SPEED_MAX;
      speed_min_r <= ppsy_pkg::RST_SPEED_MIN;
      gain_r      <= ppsy_pkg::RST_CURV_GAIN;
      yaw_max_r   <= ppsy_pkg::RST_YAW_MAX;
      look_min_r  <= ppsy_pkg::RST_LOOK_MIN;
      timeout_r   <= ppsy_pkg::RST_TIMEOUT;
    end else begin
      speed_max_r <= speed_max_nxt;
      speed_min_r <= speed_min_nxt;
      gain_r      <= gain_nxt;
      yaw_max_r   <= yaw_max_nxt;
      look_min_r  <= look_min_nxt;
      timeout_r   <= timeout_nxt;
    end
  end

  ppsy_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ppsy_datapath #(
    .COS_FRACTION_BITS (COS_FRACTION_BITS),
    .AGE_BITS          (AGE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_lateral_error_mm (in_ch.lateral_error_mm),
    .in_lookahead_mm     (in_ch.lookahead_mm),
    .in_heading_error    (in_ch.heading_error),
    .in_curvature        (in_ch.curvature),
    .speed_max           (speed_max_r),
    .speed_min           (speed_min_r),
    .curvature_gain      (gain_r),
    .yaw_rate_max        (yaw_max_r),
    .lookahead_min_mm    (look_min_r),
    .timeout_ticks       (timeout_r),
    .out_speed           (out_ch.speed),
    .out_yaw_rate        (out_ch.yaw_rate),
    .out_stale           (out_ch.stale)
  );
endmodule
`default_nettype wire

// File: rtl/ppsy_datapath.sv
// Datapath: watchdog age, CORDIC cosine, multipliers, shared divider, output word.
`default_nettype none
`include "assert_macros.svh"
module ppsy_datapath #(
  parameter int COS_FRACTION_BITS = 12,
  parameter int AGE_BITS          = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppsy_pkg::dp_cmd_t   cmd,
  output ppsy_pkg::dp_stat_t  stat,
  input  logic signed [15:0]  in_lateral_error_mm,
  input  logic        [15:0]  in_lookahead_mm,
  input  logic signed [14:0]  in_heading_error,
  input  logic signed [15:0]  in_curvature,
  input  logic        [14:0]  speed_max,
  input  logic        [14:0]  speed_min,
  input  logic        [15:0]  curvature_gain,
  input  logic        [14:0]  yaw_rate_max,
  input  logic        [15:0]  lookahead_min_mm,
  input  logic        [7:0]   timeout_ticks,
  output logic        [14:0]  out_speed,
  output logic signed [15:0]  out_yaw_rate,
  output logic                out_stale
);
  localparam int F    = COS_FRACTION_BITS;
  localparam int CW   = F + 2;
  localparam int DIVW = 52 + F;
  localparam int CMPW = (AGE_BITS > 8) ? AGE_BITS : 8;
  localparam int XW   = ppsy_pkg::XW;
  localparam int DQW  = ppsy_pkg::DQW;
  localparam int PAW  = ppsy_pkg::PAW;

  logic                 seen_r, seen_nxt;
  logic [AGE_BITS-1:0]  age_r, age_nxt, age_inc;
  logic                 stale_hit;
  logic signed [15:0]   lat_r, lat_nxt;
  logic        [15:0]   look_r, look_nxt;
  logic signed [15:0]   curv_r, curv_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic        [4:0]    cnt_r, cnt_nxt;
  logic signed [CW-1:0] cos_r, cos_nxt;
  logic [PAW-1:0]       pa_r, pa_nxt;
  logic [31:0]          pb_r, pb_nxt;
  logic [DIVW-1:0]      rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [DQW-1:0]       q_r, q_nxt;
  logic [14:0]          speed_r, speed_nxt;
  logic signed [15:0]   yaw_r, yaw_nxt;
  logic                 stale_r, stale_nxt;
  logic [14:0]          ospeed_r, ospeed_nxt;
  logic signed [15:0]   oyaw_r, oyaw_nxt;
  logic                 ostale_r, ostale_nxt;

  // combinational helpers
  logic signed [15:0]   h_ext, h_abs;
  logic signed [XW-1:0] z0, dx, dy, rsh, rcl, lim;
  logic [15:0]          kabs, latabs;
  logic signed [16:0]   k_ext, l_ext;
  logic [DIVW-1:0]      den;
  logic                 ge;
  logic [DQW-1:0]       vraw;
  logic [14:0]          qsat;

  // watchdog age
  always_comb begin
    age_inc   = (age_r == {AGE_BITS{1'b1}}) ? age_r : age_r + 1'b1;
    stale_hit = seen_r && (CMPW'(age_inc) > CMPW'(timeout_ticks));
  end

  assign stat.cordic_last = (cnt_r == 5'(ppsy_pkg::CORDIC_STEPS - 1));
  assign stat.div_last    = (cnt_r == 5'(DQW - 1));
  assign stat.stale_hit   = stale_hit;

  // operand preparation
  always_comb begin
    h_ext  = 16'(in_heading_error);
    h_abs  = h_ext[15] ? -h_ext : h_ext;
    z0     = XW'(h_abs) <<< 18;
    dx     = y_r >>> cnt_r;
    dy     = x_r >>> cnt_r;
    rsh    = (x_r + (XW'(1) <<< (29 - F))) >>> (30 - F);
    lim    = XW'(1) <<< F;
    if (rsh > lim) begin
      rcl = lim;
    end else if (rsh < -lim) begin
      rcl = -lim;
    end else begin
      rcl = rsh;
    end
    k_ext  = 17'(curv_r);
    kabs   = k_ext[16] ? 16'(-k_ext) : 16'(k_ext);
    l_ext  = 17'(lat_r);
    latabs = l_ext[16] ? 16'(-l_ext) : 16'(l_ext);
    den    = (DIVW'(pb_r) + DIVW'(256)) << F;
    ge     = (rem_r >= dsh_r);
    vraw   = (cos_r <= 0) ? '0 : q_r;
    qsat   = (q_r > DQW'(yaw_rate_max)) ? yaw_rate_max : q_r[14:0];
  end

  // next state per operation
  always_comb begin
    seen_nxt  = seen_r;   age_nxt  = age_r;
    lat_nxt   = lat_r;    look_nxt = look_r;  curv_nxt = curv_r;
    neg_nxt   = neg_r;    x_nxt    = x_r;     y_nxt    = y_r;   z_nxt = z_r;
    cnt_nxt   = cnt_r;    cos_nxt  = cos_r;
    pa_nxt    = pa_r;     pb_nxt   = pb_r;
    rem_nxt   = rem_r;    dsh_nxt  = dsh_r;   q_nxt    = q_r;
    speed_nxt = speed_r;  yaw_nxt  = yaw_r;   stale_nxt = stale_r;
    ospeed_nxt = ospeed_r; oyaw_nxt = oyaw_r; ostale_nxt = ostale_r;

    unique case (cmd.op)
      ppsy_pkg::OP_TICK: begin
        age_nxt   = age_inc;
        speed_nxt = '0;
        yaw_nxt   = '0;
        stale_nxt = 1'b1;
      end
      ppsy_pkg::OP_SAMPLE: begin
        seen_nxt  = 1'b1;
        age_nxt   = '0;
        lat_nxt   = in_lateral_error_mm;
        look_nxt  = in_lookahead_mm;
        curv_nxt  = in_curvature;
        stale_nxt = 1'b0;
        x_nxt     = ppsy_pkg::CORDIC_GAIN_Q30;
        y_nxt     = '0;
        cnt_nxt   = '0;
        // reflect angles past a right angle
        if (z0 > ppsy_pkg::HALF_PI_Q30) begin
          z_nxt   = ppsy_pkg::PI_Q30 - z0;
          neg_nxt = 1'b1;
        end else begin
          z_nxt   = z0;
          neg_nxt = 1'b0;
        end
      end
      ppsy_pkg::OP_CORDIC: begin
        if (z_r >= 0) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - ppsy_pkg::atan_q30(cnt_r);
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + ppsy_pkg::atan_q30(cnt_r);
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      ppsy_pkg::OP_COSFIN: begin
        cos_nxt = neg_r ? CW'(-rcl) : CW'(rcl);
      end
      ppsy_pkg::OP_SMUL: begin
        pa_nxt = PAW'(speed_max * cos_r[F:0]);
        pb_nxt = 32'(curvature_gain * kabs);
      end
      ppsy_pkg::OP_SDIV_LOAD: begin
        rem_nxt = (DIVW'(pa_r) << 9) + den;
        dsh_nxt = den << DQW;
        q_nxt   = '0;
        cnt_nxt = '0;
      end
      ppsy_pkg::OP_DIV_STEP: begin
        rem_nxt = ge ? rem_r - dsh_r : rem_r;
        dsh_nxt = dsh_r >> 1;
        q_nxt   = {q_r[DQW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      ppsy_pkg::OP_SFIN: begin
        // lower bound wins over upper bound
        if (vraw < DQW'(speed_min)) begin
          speed_nxt = speed_min;
        end else if (vraw > DQW'(speed_max)) begin
          speed_nxt = speed_max;
        end else begin
          speed_nxt = vraw[14:0];
        end
      end
      ppsy_pkg::OP_YMUL1: begin
        pa_nxt = PAW'(speed_r * latabs);
        pb_nxt = look_r * look_r;
      end
      ppsy_pkg::OP_YMUL2: begin
        pa_nxt = PAW'(pa_r[30:0] * ppsy_pkg::YAW_GAIN);
      end
      ppsy_pkg::OP_YDIV_LOAD: begin
        rem_nxt = (DIVW'(pa_r) << 1) + DIVW'(pb_r);
        dsh_nxt = DIVW'(pb_r) << DQW;
        q_nxt   = '0;
        cnt_nxt = '0;
      end
      ppsy_pkg::OP_YFIN: begin
        if (look_r > lookahead_min_mm) begin
          yaw_nxt = lat_r[15] ? -16'(qsat) : 16'(qsat);
        end else begin
          yaw_nxt = '0;
        end
      end
      default: begin
      end
    endcase

    // output word register
    if (cmd.out_load) begin
      ospeed_nxt = speed_r;
      oyaw_nxt   = yaw_r;
      ostale_nxt = stale_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      age_r  <= '0;
      cnt_r  <= '0;
    end else begin
      seen_r <= seen_nxt;
      age_r  <= age_nxt;
      cnt_r  <= cnt_nxt;
    end
    lat_r    <= lat_nxt;   look_r  <= look_nxt;  curv_r <= curv_nxt;
    neg_r    <= neg_nxt;   x_r     <= x_nxt;     y_r    <= y_nxt;   z_r <= z_nxt;
    cos_r    <= cos_nxt;   pa_r    <= pa_nxt;    pb_r   <= pb_nxt;
    rem_r    <= rem_nxt;   dsh_r   <= dsh_nxt;   q_r    <= q_nxt;
    speed_r  <= speed_nxt; yaw_r   <= yaw_nxt;   stale_r <= stale_nxt;
    ospeed_r <= ospeed_nxt; oyaw_r <= oyaw_nxt;  ostale_r <= ostale_nxt;
  end

  assign out_speed    = ospeed_r;
  assign out_yaw_rate = oyaw_r;
  assign out_stale    = ostale_r;

  // speed lands inside the window when the window is well formed
  `PPSY_ASSERT_NEXT(a_speed_window,
    cmd.op == ppsy_pkg::OP_SFIN && speed_min <= speed_max,
    speed_r >= speed_min && speed_r <= speed_max,
    "speed outside min/max window")
endmodule
`default_nettype wire

// File: rtl/ppsy_ctrl.sv
// Controller: sequences one item at a time through the datapath.
`default_nettype none
`include "assert_macros.svh"
module ppsy_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ppsy_pkg::dp_cmd_t  cmd,
  input  ppsy_pkg::dp_stat_t stat
);
  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_CORDIC  = 13'b0000000000010,
    S_COSFIN  = 13'b0000000000100,
    S_SMUL    = 13'b0000000001000,
    S_SDLOAD  = 13'b0000000010000,
    S_SDIV    = 13'b0000000100000,
    S_SFIN    = 13'b0000001000000,
    S_YMUL1   = 13'b0000010000000,
    S_YMUL2   = 13'b0000100000000,
    S_YDLOAD  = 13'b0001000000000,
    S_YDIV    = 13'b0010000000000,
    S_YFIN    = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = ppsy_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind) begin
            cmd.op    = ppsy_pkg::OP_TICK;
            state_nxt = stat.stale_hit ? S_DONE : S_IDLE;
          end else begin
            cmd.op    = ppsy_pkg::OP_SAMPLE;
            state_nxt = S_CORDIC;
          end
        end
      end
      S_CORDIC: begin
        cmd.op = ppsy_pkg::OP_CORDIC;
        if (stat.cordic_last) begin
          state_nxt = S_COSFIN;
        end
      end
      S_COSFIN: begin
        cmd.op = ppsy_pkg::OP_COSFIN;  state_nxt = S_SMUL;
      end
      S_SMUL: begin
        cmd.op = ppsy_pkg::OP_SMUL;    state_nxt = S_SDLOAD;
      end
      S_SDLOAD: begin
        cmd.op = ppsy_pkg::OP_SDIV_LOAD; state_nxt = S_SDIV;
      end
      S_SDIV: begin
        cmd.op = ppsy_pkg::OP_DIV_STEP;
        if (stat.div_last) begin
          state_nxt = S_SFIN;
        end
      end
      S_SFIN: begin
        cmd.op = ppsy_pkg::OP_SFIN;    state_nxt = S_YMUL1;
      end
      S_YMUL1: begin
        cmd.op = ppsy_pkg::OP_YMUL1;   state_nxt = S_YMUL2;
      end
      S_YMUL2: begin
        cmd.op = ppsy_pkg::OP_YMUL2;   state_nxt = S_YDLOAD;
      end
      S_YDLOAD: begin
        cmd.op = ppsy_pkg::OP_YDIV_LOAD; state_nxt = S_YDIV;
      end
      S_YDIV: begin
        cmd.op = ppsy_pkg::OP_DIV_STEP;
        if (stat.div_last) begin
          state_nxt = S_YFIN;
        end
      end
      S_YFIN: begin
        cmd.op = ppsy_pkg::OP_YFIN;    state_nxt = S_DONE;
      end
      S_DONE: begin
        // hand the word over once the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `PPSY_ASSERT(a_no_overwrite, !(cmd.out_load && out_valid_r && !out_ready),
    "output word overwritten before taken")
  `PPSY_ASSERT_NEXT(a_cordic_runs,
    state_r == S_CORDIC && !stat.cordic_last, state_r == S_CORDIC,
    "CORDIC left early")
  `PPSY_ASSERT_NEXT(a_div_runs,
    state_r == S_SDIV && !stat.div_last, state_r == S_SDIV,
    "speed division left early")
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the pure pursuit speed and yaw controller: stimulus, prediction and checks.
`default_nettype none

// One input word as the predictor sees it.
typedef struct {
  bit                 kind;
  bit signed [15:0]   lat;
  bit        [15:0]   look;
  bit signed [14:0]   head;
  bit signed [15:0]   curv;
} cmd_in_t;

// One drive command.
typedef struct {
  bit        [14:0]   speed;
  bit signed [15:0]   yaw;
  bit                 stale;
} drive_cmd_t;

// Drive command predictor and store of commands still to come.
class drive_scoreboard;
  longint unsigned speed_max, speed_min, curv_gain, yaw_max, look_min, timeout;
  bit              have_sample;
  longint unsigned age;
  drive_cmd_t      pending_cmds[$];
  int              errors;
  int              n_checked, n_stale;
  longint          atan_tab[30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2};

  function new();
    speed_max = 2048; speed_min = 410; curv_gain = 500;
    yaw_max = 8192; look_min = 50; timeout = 5;
    have_sample = 0; age = 0; errors = 0; n_checked = 0; n_stale = 0;
  endfunction

  function void set_reg(logic [2:0] idx, longint unsigned val);
    case (idx)
      ppsy_pkg::REG_SPEED_MAX: speed_max = val & 16'h7fff;
      ppsy_pkg::REG_SPEED_MIN: speed_min = val & 16'h7fff;
      ppsy_pkg::REG_CURV_GAIN: curv_gain = val & 16'hffff;
      ppsy_pkg::REG_YAW_MAX:   yaw_max   = val & 16'h7fff;
      ppsy_pkg::REG_LOOK_MIN:  look_min  = val & 16'hffff;
      ppsy_pkg::REG_TIMEOUT:   timeout   = val & 8'hff;
      default: ;
    endcase
  endfunction

  // CORDIC cosine, Q30 inside, rounded to Q.12
  function longint cos_q12(longint h);
    longint a, z, x, y, dx, dy, r;
    bit     neg;
    a = (h < 0) ? -h : h;
    z = a * 262144;
    x = 652032874; y = 0; neg = 0;
    if (z > 64'sd1686629713) begin
      z = 64'sd3373259426 - z;
      neg = 1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    r = (x + (64'sd1 << 17)) >>> 18;
    if (r > 4096) r = 4096;
    if (r < -4096) r = -4096;
    return neg ? -r : r;
  endfunction

  // note an accepted input word and queue the command it causes
  function void note_input(cmd_in_t w);
    drive_cmd_t      d;
    longint          c, lat;
    longint unsigned v, num, den, kabs, latabs, mag, l2, q;
    if (w.kind) begin
      if (age < 255) age++;
      if (have_sample && age > timeout) begin
        d.speed = 0; d.yaw = 0; d.stale = 1;
        pending_cmds.push_back(d);
      end
      return;
    end
    have_sample = 1;
    age = 0;
    c = cos_q12(longint'(w.head));
    if (c <= 0) v = 0;
    else begin
      kabs = (w.curv < 0) ? -longint'(w.curv) : longint'(w.curv);
      num = speed_max * longint'(c) * 256;
      den = (256 + curv_gain * kabs) << 12;
      v = (2 * num + den) / (2 * den);
    end
    if (v < speed_min) v = speed_min;
    else if (v > speed_max) v = speed_max;
    d.yaw = 0;
    if (longint'(w.look) > look_min) begin
      lat = longint'(w.lat);
      latabs = (lat < 0) ? -lat : lat;
      mag = 2000 * v * latabs;
      l2 = longint'(w.look) * longint'(w.look);
      q = (2 * mag + l2) / (2 * l2);
      if (q > yaw_max) q = yaw_max;
      d.yaw = (lat < 0) ? 16'(-longint'(q)) : 16'(longint'(q));
    end
    d.speed = v[14:0];
    d.stale = 0;
    pending_cmds.push_back(d);
  endfunction

  // compare one received word with the oldest expected command
  function void check_word(bit [14:0] speed, bit signed [15:0] yaw, bit stale);
    drive_cmd_t e;
    if (pending_cmds.size() == 0) begin
      $error("unexpected word: speed=%0d yaw_rate=%0d stale=%0b", speed, yaw, stale);
      errors++;
      return;
    end
    e = pending_cmds.pop_front();
    n_checked++;
    if (stale) n_stale++;
    if (speed !== e.speed) begin
      $error("speed: expected %0d, got %0d", e.speed, speed); errors++;
    end
    if (yaw !== e.yaw) begin
      $error("yaw_rate: expected %0d, got %0d", e.yaw, yaw); errors++;
    end
    if (stale !== e.stale) begin
      $error("stale: expected %0b, got %0b", e.stale, stale); errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ppsy_in_if  in_ch();
  ppsy_out_if out_ch();

  pure_pursuit_speed_yaw_controller_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  drive_scoreboard cmd_sb = new();
  int     send_gap_pct, recv_gap_pct;
  bit     holdoff_req, holdoff;
  longint cycles;
  int     n_words_in, n_phases;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog on the whole run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // long receiver hold-off, requested by the main sequence
  initial begin
    holdoff = 0;
    wait (holdoff_req);
    @(posedge clk);
    holdoff = 1;
    repeat (600) @(posedge clk);
    holdoff = 0;
  end

  // result side: check accepted words, then pick next ready
  initial out_ch.ready = 0;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      cmd_sb.check_word(out_ch.speed, out_ch.yaw_rate, out_ch.stale);
    out_ch.ready <= !holdoff && ($urandom_range(99) >= recv_gap_pct);
  end

  // APB register write: setup then access
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    cmd_sb.set_reg(idx, val);
  endtask

  task automatic write_all(int smax, int smin, int gain, int ymax, int lmin, int tmo);
    reg_write(ppsy_pkg::REG_SPEED_MAX, smax);
    reg_write(ppsy_pkg::REG_SPEED_MIN, smin);
    reg_write(ppsy_pkg::REG_CURV_GAIN, gain);
    reg_write(ppsy_pkg::REG_YAW_MAX, ymax);
    reg_write(ppsy_pkg::REG_LOOK_MIN, lmin);
    reg_write(ppsy_pkg::REG_TIMEOUT, tmo);
  endtask

  // offer one word; returns after it is accepted
  task automatic send_word(cmd_in_t w);
    if ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_ch.valid <= 1;
    in_ch.kind <= w.kind;
    in_ch.lateral_error_mm <= w.lat;
    in_ch.lookahead_mm <= w.look;
    in_ch.heading_error <= w.head;
    in_ch.curvature <= w.curv;
    do @(posedge clk); while (!in_ch.ready);
    cmd_sb.note_input(w);
    n_words_in++;
  endtask

  task automatic send_sample(int lat, int look, int head, int curv);
    cmd_in_t w;
    w.kind = 0; w.lat = 16'(lat); w.look = 16'(look); w.head = 15'(head);
    w.curv = 16'(curv);
    send_word(w);
  endtask

  task automatic send_tick();
    cmd_in_t w;
    w.kind = 1; w.lat = 16'($urandom); w.look = 16'($urandom);
    w.head = 15'($urandom); w.curv = 16'($urandom);
    send_word(w);
  endtask

  // wait until every expected command has come, plus pipeline slack
  task automatic drain();
    in_ch.valid <= 0;
    while (cmd_sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // random mix: mostly samples, with tick bursts to reach the timeout
  task automatic random_words(int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(10, 1)) begin
          send_tick(); k++;
        end
      end else if ($urandom_range(99) < 40) begin
        send_sample($urandom, $urandom, $urandom, $urandom);
        k++;
      end else begin
        send_sample($urandom_range(4000) - 2000, $urandom_range(6000, 20),
                    $urandom_range(13000) - 6500, $urandom_range(600) - 300);
        k++;
      end
    end
  endtask

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0; in_ch.kind = 0; in_ch.lateral_error_mm = 0;
    in_ch.lookahead_mm = 0; in_ch.heading_error = 0; in_ch.curvature = 0;
    holdoff_req = 0; n_words_in = 0; n_phases = 0;
    send_gap_pct = 0; recv_gap_pct = 0;
    rst_n = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: ticks before any sample, then field extremes at reset settings
    repeat (8) send_tick();
    send_sample(0, 0, 0, 0);
    send_sample(32767, 51, 0, 0);
    send_sample(-32768, 51, 0, 0);
    send_sample(1000, 50, 0, 0);
    send_sample(1000, 65535, 0, 0);
    send_sample(500, 1000, 12868, 32767);
    send_sample(-500, 1000, -12868, -32768);
    send_sample(500, 1000, 6434, 0);
    send_sample(500, 1000, -6434, 0);
    send_sample(500, 1000, 16383, 0);
    send_sample(500, 1000, -16384, 0);
    send_sample(20, 200, 100, 1);
    repeat (7) send_tick();
    drain();

    // register extremes and random settings
    for (int p = 0; p < 8; p++) begin
      n_phases++;
      send_gap_pct = (p < 3) ? 7 : (p < 6) ? 47 : 0;
      recv_gap_pct = (p < 3) ? 47 : (p < 6) ? 7 : 0;
      case (p)
        0: write_all(32767, 0, 0, 32767, 0, 0);
        1: write_all(0, 0, 65535, 0, 65535, 255);
        2: write_all(1000, 3000, 1, 100, 1000, 1);
        3: write_all(32767, 32767, 65535, 32767, 0, 254);
        default: write_all($urandom_range(32767), $urandom_range(2000),
                           $urandom_range(2000), $urandom_range(32767),
                           $urandom_range(300), $urandom_range(12));
      endcase
      if (p == 6) holdoff_req = 1;
      random_words(250);
      drain();
    end

    $display("Sent %0d words over %0d register settings; %0d commands checked, %0d stale.",
             n_words_in, n_phases + 1, cmd_sb.n_checked, cmd_sb.n_stale);
    if (cmd_sb.errors == 0 && cmd_sb.pending_cmds.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
